// ----- rtl/rna_pkg.sv -----
// ----------------------------------------------------------------------------
// rna_pkg: rational number alu shared definitions
// operand widths, stream packing, operation and error codes, sequencer states
// ----------------------------------------------------------------------------
package rna_pkg;

  localparam int OperandW = 16;
  localparam int NumW     = OperandW;
  localparam int DenW     = OperandW - 1;
  localparam int ModeW    = 4;
  // products and reduced magnitudes
  localparam int WideW    = 2 * OperandW;
  localparam int ProdW    = 2 * OperandW + 2;
  localparam int CntW     = $clog2(WideW);

  localparam int ResNumW  = 32;
  localparam int ResDenW  = 31;
  localparam int ErrW     = 2;

  localparam int InBits   = ModeW + NumW + DenW + NumW + DenW;
  localparam int InW      = ((InBits + 7) / 8) * 8;
  localparam int OutBits  = ResNumW + ResDenW + 1 + ErrW;
  localparam int OutW     = ((OutBits + 7) / 8) * 8;

  // field offsets inside the request tdata
  localparam int ModeLsb  = 0;
  localparam int AnumLsb  = ModeLsb + ModeW;
  localparam int AdenLsb  = AnumLsb + NumW;
  localparam int BnumLsb  = AdenLsb + DenW;
  localparam int BdenLsb  = BnumLsb + NumW;

  localparam logic [ModeW-1:0] ModeAdd = 4'd0;
  localparam logic [ModeW-1:0] ModeSub = 4'd1;
  localparam logic [ModeW-1:0] ModeMul = 4'd2;
  localparam logic [ModeW-1:0] ModeDiv = 4'd3;
  localparam logic [ModeW-1:0] ModeLt  = 4'd4;
  localparam logic [ModeW-1:0] ModeLe  = 4'd5;
  localparam logic [ModeW-1:0] ModeGt  = 4'd6;
  localparam logic [ModeW-1:0] ModeGe  = 4'd7;
  localparam logic [ModeW-1:0] ModeEq  = 4'd8;
  localparam logic [ModeW-1:0] ModeNe  = 4'd9;

  localparam logic [ErrW-1:0] ErrNone   = 2'd0;
  localparam logic [ErrW-1:0] ErrDivZero = 2'd1;
  localparam logic [ErrW-1:0] ErrBadDen = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_MUL_D,
    ST_COMBINE,
    ST_SIGN,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/rational_number_alu.sv -----
// ----------------------------------------------------------------------------
// rational_number_alu: add, subtract, multiply, divide and compare fractions
// one request at a time, reduced through a shared subtract and shift datapath
// ----------------------------------------------------------------------------
// Compares and errors pass from the accepting edge through ST_MUL_L, ST_MUL_R and
// ST_MUL_D on the one 17x17 multiplier for the products, then the combine state,
// then the result is loaded. A zero fraction result also passes ST_SIGN. Any
// other fraction result takes the products and combine, ST_SIGN for the
// magnitudes, a binary gcd that retires one shift or one subtraction per cycle,
// then two restoring divisions by the gcd, numerator then denominator, on the
// same subtractor before the result is loaded. The request side is ready only
// while the sequencer is idle; the result sits in its own output register, so
// the next request is taken while an earlier result still waits on m_axis_tready.
module rational_number_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // mode[3:0], a_num[19:4], a_den[34:20], b_num[50:35], b_den[65:51], zero pad
  input  logic [rna_pkg::InW-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // result_num[31:0], result_den[62:32], compare_true[63], error_code[65:64],
  // zero pad
  output logic [rna_pkg::OutW-1:0] m_axis_tdata
);
  import rna_pkg::*;

  state_e state_q, state_d;

  logic [ModeW-1:0]        mode_q, mode_d;
  logic signed [NumW-1:0]  an_q, an_d, bn_q, bn_d;
  logic [DenW-1:0]         ad_q, ad_d, bd_q, bd_d;

  logic signed [WideW-1:0] l_q, l_d, r_q, r_d, dn_q, dn_d, n_q, n_d;
  logic [WideW-1:0]        x_q, x_d, y_q, y_d, mn_q, mn_d, md_q, md_d;
  logic [WideW-1:0]        g_q, g_d, rem_q, rem_d, quo_q, quo_d, qnum_q, qnum_d;
  logic [CntW-1:0]         k_q, k_d, cnt_q, cnt_d;
  logic                    neg_q, neg_d;

  logic [ResNumW-1:0]      res_num_q, res_num_d;
  logic [ResDenW-1:0]      res_den_q, res_den_d;
  logic                    res_cmp_q, res_cmp_d;
  logic [ErrW-1:0]         res_err_q, res_err_d;

  logic                    out_valid_q, out_valid_d;
  logic [ResNumW-1:0]      out_num_q, out_num_d;
  logic [ResDenW-1:0]      out_den_q, out_den_d;
  logic                    out_cmp_q, out_cmp_d;
  logic [ErrW-1:0]         out_err_q, out_err_d;

  // shared multiplier
  logic signed [NumW:0]    mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [WideW-1:0] prod_w;

  // shared subtractor
  logic [WideW:0]          sub_a, sub_b, diff;
  logic [WideW:0]          rem_sh;
  logic                    x_ge_y;
  logic                    div_bit;
  logic [WideW-1:0]        div_rem, div_quo;
  logic [WideW-1:0]        n_mag, d_mag, signed_q;

  always_comb begin
    mul_a = {an_q[NumW-1], an_q};
    mul_b = {2'b00, bd_q};
    case (state_q)
      ST_MUL_L: begin
        mul_a = {an_q[NumW-1], an_q};
        mul_b = {2'b00, bd_q};
      end
      ST_MUL_R: begin
        // multiply needs a_num*b_num, the cross term is unused there
        mul_a = {bn_q[NumW-1], bn_q};
        mul_b = (mode_q == ModeMul) ? {an_q[NumW-1], an_q} : {2'b00, ad_q};
      end
      ST_MUL_D: begin
        mul_a = {2'b00, ad_q};
        mul_b = (mode_q == ModeDiv) ? {bn_q[NumW-1], bn_q} : {2'b00, bd_q};
      end
      default: begin
        mul_a = {an_q[NumW-1], an_q};
        mul_b = {2'b00, bd_q};
      end
    endcase
    prod   = ProdW'(mul_a) * ProdW'(mul_b);
    prod_w = prod[WideW-1:0];
  end

  assign x_ge_y = (x_q >= y_q);
  assign rem_sh = {rem_q, quo_q[WideW-1]};

  always_comb begin
    if (state_q == ST_GCD) begin
      sub_a = x_ge_y ? {1'b0, x_q} : {1'b0, y_q};
      sub_b = x_ge_y ? {1'b0, y_q} : {1'b0, x_q};
    end else begin
      sub_a = rem_sh;
      sub_b = {1'b0, g_q};
    end
    diff = sub_a - sub_b;
  end

  // one restoring division step
  assign div_bit = ~diff[WideW];
  assign div_rem = div_bit ? diff[WideW-1:0] : rem_sh[WideW-1:0];
  assign div_quo = {quo_q[WideW-2:0], div_bit};

  assign n_mag    = n_q[WideW-1] ? WideW'(-n_q) : WideW'(n_q);
  assign d_mag    = dn_q[WideW-1] ? WideW'(-dn_q) : WideW'(dn_q);
  assign signed_q = neg_q ? (~qnum_q + WideW'(1)) : qnum_q;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    l_d         = l_q;
    r_d         = r_q;
    dn_d        = dn_q;
    n_d         = n_q;
    x_d         = x_q;
    y_d         = y_q;
    mn_d        = mn_q;
    md_d        = md_q;
    g_d         = g_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    qnum_d      = qnum_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    res_cmp_d   = res_cmp_q;
    res_err_d   = res_err_q;
    out_valid_d = out_valid_q;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_cmp_d   = out_cmp_q;
    out_err_d   = out_err_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = s_axis_tdata[ModeLsb +: ModeW];
          an_d    = s_axis_tdata[AnumLsb +: NumW];
          ad_d    = s_axis_tdata[AdenLsb +: DenW];
          bn_d    = s_axis_tdata[BnumLsb +: NumW];
          bd_d    = s_axis_tdata[BdenLsb +: DenW];
          state_d = ST_MUL_L;
        end
      end
      ST_MUL_L: begin
        l_d     = prod_w;
        state_d = ST_MUL_R;
      end
      ST_MUL_R: begin
        r_d     = prod_w;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        dn_d    = prod_w;
        state_d = ST_COMBINE;
      end
      ST_COMBINE: begin
        res_num_d = '0;
        res_den_d = ResDenW'(1);
        res_cmp_d = 1'b0;
        res_err_d = ErrNone;
        state_d   = ST_DONE;
        if (ad_q == '0 || bd_q == '0) begin
          res_err_d = ErrBadDen;
        end else begin
          case (mode_q)
            ModeAdd: begin
              n_d     = l_q + r_q;
              state_d = ST_SIGN;
            end
            ModeSub: begin
              n_d     = l_q - r_q;
              state_d = ST_SIGN;
            end
            ModeMul: begin
              n_d     = r_q;
              state_d = ST_SIGN;
            end
            ModeDiv: begin
              if (bn_q == '0) begin
                res_err_d = ErrDivZero;
              end else begin
                n_d     = l_q;
                state_d = ST_SIGN;
              end
            end
            ModeLt:  res_cmp_d = (l_q < r_q);
            ModeLe:  res_cmp_d = (l_q <= r_q);
            ModeGt:  res_cmp_d = (l_q > r_q);
            ModeGe:  res_cmp_d = (l_q >= r_q);
            ModeEq:  res_cmp_d = (l_q == r_q);
            ModeNe:  res_cmp_d = (l_q != r_q);
            default: res_cmp_d = 1'b0;
          endcase
        end
      end
      ST_SIGN: begin
        x_d   = n_mag;
        y_d   = d_mag;
        mn_d  = n_mag;
        md_d  = d_mag;
        neg_d = n_q[WideW-1] ^ dn_q[WideW-1];
        k_d   = '0;
        // zero numerator stays 0/1
        state_d = (n_mag == '0) ? ST_DONE : ST_GCD;
      end
      ST_GCD: begin
        if (x_q == '0 || y_q == '0) begin
          g_d     = (x_q | y_q) << k_q;
          rem_d   = '0;
          quo_d   = mn_q;
          cnt_d   = '0;
          state_d = ST_DIV_NUM;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + CntW'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_ge_y) begin
          x_d = diff[WideW-1:0];
        end else begin
          y_d = diff[WideW-1:0];
        end
      end
      ST_DIV_NUM: begin
        rem_d = div_rem;
        quo_d = div_quo;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(WideW - 1)) begin
          qnum_d  = div_quo;
          rem_d   = '0;
          quo_d   = md_q;
          cnt_d   = '0;
          state_d = ST_DIV_DEN;
        end
      end
      ST_DIV_DEN: begin
        rem_d = div_rem;
        quo_d = div_quo;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(WideW - 1)) begin
          res_num_d = ResNumW'(signed'(signed_q));
          res_den_d = ResDenW'(div_quo);
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_num_d   = res_num_q;
          out_den_d   = res_den_q;
          out_cmp_d   = res_cmp_q;
          out_err_d   = res_err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    l_q       <= l_d;
    r_q       <= r_d;
    dn_q      <= dn_d;
    n_q       <= n_d;
    x_q       <= x_d;
    y_q       <= y_d;
    mn_q      <= mn_d;
    md_q      <= md_d;
    g_q       <= g_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    qnum_q    <= qnum_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_cmp_q <= res_cmp_d;
    res_err_q <= res_err_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_cmp_q <= out_cmp_d;
    out_err_q <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutW - OutBits)'(0), out_err_q, out_cmp_q, out_den_q, out_num_q};

endmodule

// ----- tb/sv/rna_result_checker.sv -----
// ----------------------------------------------------------------------------
// rna_result_checker: scoreboard for the rational number alu
// predicts the reduced fraction, compare flag and error code of every
// accepted request and checks each result against the oldest prediction
// ----------------------------------------------------------------------------
module rna_result_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_tvalid_i,
  input  logic                     s_tready_i,
  input  logic [rna_pkg::InW-1:0]  s_tdata_i,
  input  logic                     m_tvalid_i,
  input  logic                     m_tready_i,
  input  logic [rna_pkg::OutW-1:0] m_tdata_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       checked_o
);
  import rna_pkg::*;

  localparam int DenLsb = ResNumW;
  localparam int CmpBit = ResNumW + ResDenW;
  localparam int ErrLsb = CmpBit + 1;

  typedef struct packed {
    logic signed [ResNumW-1:0] num;
    logic [ResDenW-1:0]        den;
    logic                      cmp;
    logic [ErrW-1:0]           err;
  } fraction_result_t;

  fraction_result_t expected_q[$];
  fraction_result_t want;
  fraction_result_t got;
  int fails;
  int checked;

  // lowest terms, sign carried by the numerator, zero as 0/1
  function automatic fraction_result_t reduced(longint n, longint d);
    fraction_result_t r;
    longint mn;
    longint md;
    longint x;
    longint y;
    longint t;
    bit     neg;
    neg = (n < 0) != (d < 0);
    mn  = (n < 0) ? -n : n;
    md  = (d < 0) ? -d : d;
    x   = mn;
    y   = md;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) x = 1;
    mn = mn / x;
    md = md / x;
    r.cmp = 1'b0;
    r.err = ErrNone;
    if (mn == 0) begin
      r.num = '0;
      r.den = ResDenW'(1);
    end else begin
      r.num = ResNumW'(neg ? -mn : mn);
      r.den = ResDenW'(md);
    end
    return r;
  endfunction

  function automatic fraction_result_t predict_fraction(logic [InW-1:0] req);
    fraction_result_t r;
    logic [ModeW-1:0] mode;
    longint an;
    longint ad;
    longint bn;
    longint bd;
    longint l;
    longint rr;
    mode  = req[ModeLsb +: ModeW];
    an    = longint'($signed(req[AnumLsb +: NumW]));
    ad    = longint'(req[AdenLsb +: DenW]);
    bn    = longint'($signed(req[BnumLsb +: NumW]));
    bd    = longint'(req[BdenLsb +: DenW]);
    r.num = '0;
    r.den = ResDenW'(1);
    r.cmp = 1'b0;
    r.err = ErrNone;
    // a zero denominator wins over every other check
    if (ad == 0 || bd == 0) begin
      r.err = ErrBadDen;
    end else begin
      l  = an * bd;
      rr = bn * ad;
      case (mode)
        ModeAdd: r = reduced(l + rr, ad * bd);
        ModeSub: r = reduced(l - rr, ad * bd);
        ModeMul: r = reduced(an * bn, ad * bd);
        ModeDiv: begin
          if (bn == 0) r.err = ErrDivZero;
          else r = reduced(l, ad * bn);
        end
        ModeLt: r.cmp = (l < rr);
        ModeLe: r.cmp = (l <= rr);
        ModeGt: r.cmp = (l > rr);
        ModeGe: r.cmp = (l >= rr);
        ModeEq: r.cmp = (l == rr);
        ModeNe: r.cmp = (l != rr);
        default: ;
      endcase
    end
    return r;
  endfunction

  assign fail_count_o = fails;
  assign checked_o    = checked;

  // results are taken before requests: a result never belongs to a request
  // accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got.num = m_tdata_i[0 +: ResNumW];
        got.den = m_tdata_i[DenLsb +: ResDenW];
        got.cmp = m_tdata_i[CmpBit];
        got.err = m_tdata_i[ErrLsb +: ErrW];
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: num %0d den %0d cmp %0b err %0d",
                 got.num, got.den, got.cmp, got.err);
          fails++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (got.num !== want.num) begin
            $error("result_num: expected %0d, got %0d", want.num, got.num);
            fails++;
          end
          if (got.den !== want.den) begin
            $error("result_den: expected %0d, got %0d", want.den, got.den);
            fails++;
          end
          if (got.cmp !== want.cmp) begin
            $error("compare_true: expected %0b, got %0b", want.cmp, got.cmp);
            fails++;
          end
          if (got.err !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, got.err);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_q.push_back(predict_fraction(s_tdata_i));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: rational number alu stream test
// directed corner requests, then random requests under three stall profiles,
// with a long output stall and full drains; a side checker scores results
// ----------------------------------------------------------------------------
module testbench;
  import rna_pkg::*;

  localparam int WatchdogLimit  = 4000;
  localparam int HoldOffCycles  = 400;
  localparam int TailCycles     = 200;
  localparam int RequestsPerRun = 267;
  // no operation is assigned to this code
  localparam logic [ModeW-1:0] ModeUnused = 4'd15;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct;
  int recv_idle_pct;
  int n_sent;

  rational_number_alu dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rna_result_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [InW-1:0] pack_request(logic [ModeW-1:0] mode, int an, int ad,
                                                  int bn, int bd);
    logic [InW-1:0] req;
    req = '0;
    req[ModeLsb +: ModeW] = mode;
    req[AnumLsb +: NumW]  = an[NumW-1:0];
    req[AdenLsb +: DenW]  = ad[DenW-1:0];
    req[BnumLsb +: NumW]  = bn[NumW-1:0];
    req[BdenLsb +: DenW]  = bd[DenW-1:0];
    return req;
  endfunction

  function automatic logic [InW-1:0] random_request();
    logic [ModeW-1:0] mode;
    int an;
    int ad;
    int bn;
    int bd;
    if ($urandom_range(99) < 8) mode = ModeW'($urandom_range(15, 10));
    else mode = ModeW'($urandom_range(9, 0));
    // small operands give equal compares, zero results and real reductions
    if ($urandom_range(99) < 55) begin
      an = $urandom;
      ad = $urandom;
      bn = $urandom;
      bd = $urandom;
    end else begin
      an = int'($urandom_range(40)) - 20;
      ad = int'($urandom_range(12, 1));
      bn = int'($urandom_range(40)) - 20;
      bd = int'($urandom_range(12, 1));
    end
    if ($urandom_range(99) < 3) ad = 0;
    if ($urandom_range(99) < 3) bd = 0;
    return pack_request(mode, an, ad, bn, bd);
  endfunction

  // returns right after the edge that accepts the request
  task automatic send_request(logic [InW-1:0] req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    n_sent++;
  endtask

  task automatic send_fields(logic [ModeW-1:0] mode, int an, int ad, int bn, int bd);
    send_request(pack_request(mode, an, ad, bn, bd));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver: one long hold-off first, so the block fills and stalls its input
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    repeat (HoldOffCycles) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $error("no handshake for %0d cycles, %0d results outstanding", quiet, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    n_sent        = 0;
    send_idle_pct = 37;
    recv_idle_pct = 64;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    send_fields(ModeAdd, 1, 2, 1, 3);
    send_fields(ModeAdd, 2, 4, 3, 6);
    send_fields(ModeSub, 1, 2, 1, 2);
    send_fields(ModeSub, 32767, 1, -32768, 1);
    send_fields(ModeAdd, -32768, 1, -32768, 1);
    send_fields(ModeAdd, 32767, 32767, 32767, 32766);
    send_fields(ModeMul, -32768, 1, -32768, 1);
    send_fields(ModeMul, 32767, 32767, -32768, 32766);
    send_fields(ModeMul, 0, 5, 7, 3);
    send_fields(ModeDiv, 3, 4, -5, 7);
    send_fields(ModeDiv, -32768, 1, 1, 32767);
    send_fields(ModeDiv, 1, 32767, -32768, 1);
    send_fields(ModeDiv, 5, 3, 0, 9);
    send_fields(ModeAdd, 5, 0, 1, 2);
    send_fields(ModeDiv, 1, 2, 0, 0);
    send_fields(ModeEq, 1, 2, 1, 0);
    send_fields(ModeLt, 2, 4, 3, 6);
    send_fields(ModeLe, 2, 4, 3, 6);
    send_fields(ModeGt, 2, 4, 3, 6);
    send_fields(ModeGe, -32768, 1, 32767, 32767);
    send_fields(ModeEq, 2, 4, 3, 6);
    send_fields(ModeNe, 2, 4, 3, 6);
    send_fields(ModeLt, -32768, 1, 32767, 32767);
    send_fields(ModeUnused, 7, 3, 2, 5);
    send_fields(ModeNe + 4'd1, -1, 32767, -1, 32767);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (RequestsPerRun) send_request(random_request());
      drain_results();
    end

    repeat (TailCycles) @(negedge clk_i);
    $display("sent %0d requests: directed corners, then random ones under three stall mixes",
             n_sent);
    $display("checked %0d results, with a long output stall and full drains between runs",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
